@@ design/vertex_transform_clip_project_core_macros.svh @@
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_CLIP_PROJECT_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_CLIP_PROJECT_CORE_MACROS_SVH

// Generic property check
`define VTCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check
`define VTCP_ASSERT_IMP(lbl, ante, cons, msg) \
  `VTCP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ design/vtcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex transform package
// Register indexes, reset values and pipeline constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtcp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned ROW_W = 60;

  // One quotient bit per divider stage
  localparam int unsigned DIV_BITS = 48;
  // Entry register, one stage per bit, output register
  localparam int unsigned DIV_LAT = DIV_BITS + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_DEPTH = 3'd0,
    REG_ROT_HORIZ = 3'd1,
    REG_ROT_VERT  = 3'd2,
    REG_OFF_DH    = 3'd3,
    REG_OFF_VN    = 3'd4,
    REG_PIX_X     = 3'd5,
    REG_PIX_Y     = 3'd6
  } vtcp_reg_e;

  localparam logic [ROW_W-1:0] ROT_DEPTH_RST = 60'd32768;
  localparam logic [ROW_W-1:0] ROT_HORIZ_RST = 60'd34359738368;
  localparam logic [ROW_W-1:0] ROT_VERT_RST  = 60'd36028797018963968;
  localparam logic [CFG_DATA_W-1:0] OFF_DH_RST = 64'd0;
  localparam logic [CFG_DATA_W-1:0] OFF_VN_RST = 64'd281474976710656;
  localparam logic [CFG_DATA_W-1:0] PIX_X_RST  = 64'd65536;
  localparam logic [CFG_DATA_W-1:0] PIX_Y_RST  = 64'd65536;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Clip outcode bit positions
  localparam int unsigned OC_NEAR   = 0;
  localparam int unsigned OC_TOP    = 1;
  localparam int unsigned OC_BOTTOM = 2;
  localparam int unsigned OC_LEFT   = 3;
  localparam int unsigned OC_RIGHT  = 4;

  // Side information that rides alongside the divider
  typedef struct packed {
    logic              vld;
    logic              last;
    logic              zero;
    logic [4:0]        flags;
    logic signed [31:0] depth;
    logic signed [31:0] horiz;
    logic signed [31:0] vert;
  } vtcp_side_t;

endpackage

@@ design/vtcp_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Computes (num * 65536) / den truncated toward zero, saturated to 32 bits.
// One restoring step per stage; accepts a new operand pair every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtcp_div (
  input  logic               clk_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] quo_o
);

  localparam int unsigned NB = vtcp_pkg::DIV_BITS;

  logic [31:0]   rem_q [NB+1];
  logic [NB-1:0] quo_q [NB+1];
  logic [NB-1:0] dvd_q [NB+1];
  logic [31:0]   den_q [NB+1];
  logic          neg_q [NB+1];

  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [NB-1:0] mag;
  logic signed [31:0] quo_d;

  assign num_mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);

  // Entry: magnitudes and result sign
  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    quo_q[0] <= '0;
    dvd_q[0] <= {num_mag, 16'h0000};
    den_q[0] <= den_mag;
    neg_q[0] <= num_i[31] ^ den_i[31];
  end

  // One quotient bit per stage, MSB first
  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [32:0] part;
    logic [32:0] diff;
    logic        take;
    assign part = {rem_q[k], dvd_q[k][NB-1]};
    assign diff = part - {1'b0, den_q[k]};
    assign take = (part >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= take ? diff[31:0] : part[31:0];
      quo_q[k+1] <= {quo_q[k][NB-2:0], take};
      dvd_q[k+1] <= {dvd_q[k][NB-2:0], 1'b0};
      den_q[k+1] <= den_q[k];
      neg_q[k+1] <= neg_q[k];
    end
  end

  // Apply sign and saturate
  assign mag = quo_q[NB];
  always_comb begin
    if (neg_q[NB]) begin
      quo_d = (mag[NB-1:31] != '0) ? vtcp_pkg::S32_MIN : $signed(32'(-mag[31:0]));
    end else begin
      quo_d = (mag[NB-1:31] != '0) ? vtcp_pkg::S32_MAX : $signed(mag[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    quo_o <= quo_d;
  end

endmodule

@@ design/vertex_transform_clip_project_core.sv @@
// ----------------------------------------------------------------------------
// Vertex transform, clip outcodes and perspective projection
// Throughput: one vertex per cycle; busy stays low, nothing stalls.
// Depth is set by the 48-stage divider, one quotient bit per stage.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_transform_clip_project_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Vertex input
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] vertex_x_i,
  input  logic signed [31:0] vertex_y_i,
  input  logic signed [31:0] vertex_z_i,
  input  logic               clip_enable_i,
  input  logic               last_in_i,
  // Configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [vtcp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vtcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Results
  output logic               done_o,
  output logic signed [31:0] pixel_x_o,
  output logic signed [31:0] pixel_y_o,
  output logic signed [31:0] depth_o,
  output logic signed [31:0] cam_horiz_o,
  output logic signed [31:0] cam_vert_o,
  output logic [4:0]         clip_flags_o,
  output logic               zero_depth_o,
  output logic               last_out_o
);

  localparam int unsigned LAT = vtcp_pkg::DIV_LAT;

  function automatic logic signed [31:0] sat39(input logic signed [38:0] v);
    if (v[38:31] == '0 || v[38:31] == '1) return v[31:0];
    return v[38] ? vtcp_pkg::S32_MIN : vtcp_pkg::S32_MAX;
  endfunction

  function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
    if (v[48:31] == '0 || v[48:31] == '1) return v[31:0];
    return v[48] ? vtcp_pkg::S32_MIN : vtcp_pkg::S32_MAX;
  endfunction

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  logic [vtcp_pkg::ROW_W-1:0]      rot_q [3];
  logic [vtcp_pkg::CFG_DATA_W-1:0] off_dh_q, off_vn_q, pix_x_q, pix_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= vtcp_pkg::ROT_DEPTH_RST;
      rot_q[1] <= vtcp_pkg::ROT_HORIZ_RST;
      rot_q[2] <= vtcp_pkg::ROT_VERT_RST;
      off_dh_q <= vtcp_pkg::OFF_DH_RST;
      off_vn_q <= vtcp_pkg::OFF_VN_RST;
      pix_x_q  <= vtcp_pkg::PIX_X_RST;
      pix_y_q  <= vtcp_pkg::PIX_Y_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (vtcp_pkg::vtcp_reg_e'(cfg_index_i))
        vtcp_pkg::REG_ROT_DEPTH: rot_q[0] <= cfg_data_i[vtcp_pkg::ROW_W-1:0];
        vtcp_pkg::REG_ROT_HORIZ: rot_q[1] <= cfg_data_i[vtcp_pkg::ROW_W-1:0];
        vtcp_pkg::REG_ROT_VERT:  rot_q[2] <= cfg_data_i[vtcp_pkg::ROW_W-1:0];
        vtcp_pkg::REG_OFF_DH:    off_dh_q <= cfg_data_i;
        vtcp_pkg::REG_OFF_VN:    off_vn_q <= cfg_data_i;
        vtcp_pkg::REG_PIX_X:     pix_x_q  <= cfg_data_i;
        vtcp_pkg::REG_PIX_Y:     pix_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 0: input register
  logic               s0_vld_q, s0_clip_q, s0_last_q;
  logic signed [31:0] vtx_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_q[0]  <= vertex_x_i;
    vtx_q[1]  <= vertex_y_i;
    vtx_q[2]  <= vertex_z_i;
    s0_clip_q <= clip_enable_i;
    s0_last_q <= last_in_i;
  end

  // Stage 1: nine coefficient products (row r, column c)
  logic               s1_vld_q, s1_clip_q, s1_last_q;
  logic signed [51:0] prod_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= $signed(rot_q[r][20*c +: 20]) * vtx_q[c];
      end
    end
    s1_clip_q <= s0_clip_q;
    s1_last_q <= s0_last_q;
  end

  // Stage 2: row sums plus translation, floor shift by 15, saturate
  logic signed [31:0] off [3];
  logic signed [53:0] acc [3];
  logic signed [31:0] cam_d [3];

  assign off[0] = $signed(off_dh_q[31:0]);
  assign off[1] = $signed(off_dh_q[63:32]);
  assign off[2] = $signed(off_vn_q[31:0]);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = {{2{prod_q[r][0][51]}}, prod_q[r][0]}
             + {{2{prod_q[r][1][51]}}, prod_q[r][1]}
             + {{2{prod_q[r][2][51]}}, prod_q[r][2]}
             + {{7{off[r][31]}}, off[r], 15'h0000};
      cam_d[r] = sat39(acc[r][53:15]);
    end
  end

  logic               s2_vld_q, s2_clip_q, s2_last_q;
  logic signed [31:0] s2_depth_q, s2_horiz_q, s2_vert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_depth_q <= cam_d[0];
    s2_horiz_q <= cam_d[1];
    s2_vert_q  <= cam_d[2];
    s2_clip_q  <= s1_clip_q;
    s2_last_q  <= s1_last_q;
  end

  // Clip outcodes and zero depth from the camera coordinates
  logic signed [31:0] near_dist;
  logic signed [32:0] depth_w, horiz_w, vert_w, abs_h, abs_v;
  logic [4:0]         flags_d;
  vtcp_pkg::vtcp_side_t side_d;

  assign near_dist = $signed(off_vn_q[63:32]);
  assign depth_w   = {s2_depth_q[31], s2_depth_q};
  assign horiz_w   = {s2_horiz_q[31], s2_horiz_q};
  assign vert_w    = {s2_vert_q[31], s2_vert_q};
  assign abs_h     = horiz_w[32] ? -horiz_w : horiz_w;
  assign abs_v     = vert_w[32] ? -vert_w : vert_w;

  always_comb begin
    flags_d = '0;
    if (s2_clip_q) begin
      flags_d[vtcp_pkg::OC_NEAR] = (s2_depth_q < near_dist);
      if (abs_v > depth_w) begin
        if (s2_vert_q > s2_depth_q) flags_d[vtcp_pkg::OC_BOTTOM] = 1'b1;
        else                        flags_d[vtcp_pkg::OC_TOP]    = 1'b1;
      end
      if (abs_h > depth_w) begin
        if (s2_horiz_q > s2_depth_q) flags_d[vtcp_pkg::OC_RIGHT] = 1'b1;
        else                         flags_d[vtcp_pkg::OC_LEFT]  = 1'b1;
      end
    end
    side_d.vld   = s2_vld_q;
    side_d.last  = s2_last_q;
    side_d.zero  = (s2_depth_q == '0);
    side_d.flags = flags_d;
    side_d.depth = s2_depth_q;
    side_d.horiz = s2_horiz_q;
    side_d.vert  = s2_vert_q;
  end

  // Dividers, one per screen axis
  logic signed [31:0] quo_x, quo_y;

  vtcp_div u_div_x (
    .clk_i (clk_i),
    .num_i (s2_horiz_q),
    .den_i (s2_depth_q),
    .quo_o (quo_x)
  );

  vtcp_div u_div_y (
    .clk_i (clk_i),
    .num_i (s2_vert_q),
    .den_i (s2_depth_q),
    .quo_o (quo_y)
  );

  // Side line matched to the divider latency
  vtcp_pkg::vtcp_side_t side_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) side_q[k] <= '0;
    end else begin
      side_q[0] <= side_d;
      for (int k = 1; k < LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  // Pixel scale multiply
  logic signed [31:0] scale_x, scale_y, shift_x, shift_y;
  logic signed [63:0] mx_q, my_q;
  vtcp_pkg::vtcp_side_t sm_q;

  assign scale_x = $signed(pix_x_q[31:0]);
  assign shift_x = $signed(pix_x_q[63:32]);
  assign scale_y = $signed(pix_y_q[31:0]);
  assign shift_y = $signed(pix_y_q[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_q <= '0;
    end else begin
      sm_q <= side_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= scale_x * quo_x;
    my_q <= scale_y * quo_y;
  end

  // Floor shift by 16, add pixel shift, saturate; zero depth override
  logic signed [48:0] sum_x, sum_y;
  logic signed [31:0] px_d, py_d;

  assign sum_x = {mx_q[63], mx_q[63:16]} + {{17{shift_x[31]}}, shift_x};
  assign sum_y = {my_q[63], my_q[63:16]} + {{17{shift_y[31]}}, shift_y};

  always_comb begin
    if (sm_q.zero) begin
      px_d = (sm_q.horiz[31] != scale_x[31]) ? vtcp_pkg::S32_MIN : vtcp_pkg::S32_MAX;
      py_d = (sm_q.vert[31] != scale_y[31]) ? vtcp_pkg::S32_MIN : vtcp_pkg::S32_MAX;
    end else begin
      px_d = sat49(sum_x);
      py_d = sat49(sum_y);
    end
  end

  // Result registers
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sm_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_x_o    <= px_d;
    pixel_y_o    <= py_d;
    depth_o      <= sm_q.depth;
    cam_horiz_o  <= sm_q.horiz;
    cam_vert_o   <= sm_q.vert;
    clip_flags_o <= sm_q.flags;
    zero_depth_o <= sm_q.zero;
    last_out_o   <= sm_q.last;
  end

  assign done_o = done_q;

endmodule

@@ design/vtcp_checker.sv @@
// ----------------------------------------------------------------------------
// Vertex transform port checker
// Watches the top-level ports for latency and result consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertex_transform_clip_project_core_macros.svh"

module vtcp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               last_in_i,
  input logic               done_o,
  input logic signed [31:0] pixel_x_o,
  input logic signed [31:0] depth_o,
  input logic               zero_depth_o,
  input logic               last_out_o
);

  // Every transfer is followed by its done strobe
  `VTCP_ASSERT_IMP(a_latency, start && !busy, ##55 done_o, "result missing after 55 cycles")

  // Batch marker stays with its vertex
  `VTCP_ASSERT_IMP(a_last, done_o, last_out_o == $past(last_in_i, 55), "last marker misaligned")

  // Zero depth flag agrees with the depth output
  `VTCP_ASSERT_IMP(a_zero, done_o, zero_depth_o == (depth_o == 32'sd0), "zero depth mismatch")

  // Zero depth saturates the pixel output
  `VTCP_ASSERT_IMP(a_sat, done_o && zero_depth_o,
    pixel_x_o == 32'sh7FFF_FFFF || pixel_x_o == 32'sh8000_0000, "pixel not saturated")

endmodule

bind vertex_transform_clip_project_core vtcp_checker u_vtcp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .last_in_i    (last_in_i),
  .done_o       (done_o),
  .pixel_x_o    (pixel_x_o),
  .depth_o      (depth_o),
  .zero_depth_o (zero_depth_o),
  .last_out_o   (last_out_o)
);

@@ verif/vertex_transform_clip_project_core_tb.sv @@
// ----------------------------------------------------------------------------
// Vertex transform core testbench
// Streams vertices through the core under several register settings, keeps
// its own fixed-point projection model and compares every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_transform_clip_project_core_tb;

  localparam int unsigned N_RANDOM    = 1900;
  localparam int unsigned DRAIN_WAIT  = 70;
  localparam longint unsigned LIMIT   = 400000;
  // Index past the last register, writes to it must be dropped
  localparam logic [vtcp_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dep;
    logic signed [31:0] hz;
    logic signed [31:0] vt;
    logic [4:0]         flags;
    logic               zero;
    logic               last;
  } vtx_result_t;

  // Projection model plus queue of pending results
  class proj_scoreboard;
    logic [vtcp_pkg::ROW_W-1:0]      row_d, row_h, row_v;
    logic [vtcp_pkg::CFG_DATA_W-1:0] off_dh, off_vn, map_x, map_y;
    vtx_result_t           pending[$];
    int unsigned           mismatches;

    function new();
      row_d = vtcp_pkg::ROT_DEPTH_RST;
      row_h = vtcp_pkg::ROT_HORIZ_RST;
      row_v = vtcp_pkg::ROT_VERT_RST;
      off_dh = vtcp_pkg::OFF_DH_RST;
      off_vn = vtcp_pkg::OFF_VN_RST;
      map_x = vtcp_pkg::PIX_X_RST;
      map_y = vtcp_pkg::PIX_Y_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [vtcp_pkg::CFG_IDX_W-1:0] idx,
                            logic [vtcp_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        vtcp_pkg::REG_ROT_DEPTH: row_d = val[vtcp_pkg::ROW_W-1:0];
        vtcp_pkg::REG_ROT_HORIZ: row_h = val[vtcp_pkg::ROW_W-1:0];
        vtcp_pkg::REG_ROT_VERT:  row_v = val[vtcp_pkg::ROW_W-1:0];
        vtcp_pkg::REG_OFF_DH:    off_dh = val;
        vtcp_pkg::REG_OFF_VN:    off_vn = val;
        vtcp_pkg::REG_PIX_X:     map_x = val;
        vtcp_pkg::REG_PIX_Y:     map_y = val;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(vtcp_pkg::S32_MAX)) return longint'(vtcp_pkg::S32_MAX);
      if (v < longint'(vtcp_pkg::S32_MIN)) return longint'(vtcp_pkg::S32_MIN);
      return v;
    endfunction

    // Row dot vertex plus offset, Q23.31 sum floored back to Q16.16
    function longint camera(logic [vtcp_pkg::ROW_W-1:0] row, longint vx, longint vy,
                            longint vz, logic signed [31:0] off);
      longint acc;
      acc = longint'($signed(row[19:0])) * vx
          + longint'($signed(row[39:20])) * vy
          + longint'($signed(row[59:40])) * vz
          + longint'(off) * 32768;
      return clamp32(acc >>> 15);
    endfunction

    function longint pixel(longint cam, longint dep, logic [vtcp_pkg::CFG_DATA_W-1:0] map);
      longint scale, shift, q;
      scale = longint'($signed(map[31:0]));
      shift = longint'($signed(map[63:32]));
      if (dep == 0)
        return ((cam < 0) != (scale < 0)) ? longint'(vtcp_pkg::S32_MIN)
                                          : longint'(vtcp_pkg::S32_MAX);
      q = clamp32((cam * 65536) / dep);
      return clamp32(((scale * q) >>> 16) + shift);
    endfunction

    function void note_input(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic clip, logic last);
      vtx_result_t r;
      longint d, h, v, nr, ah, av;
      d = camera(row_d, x, y, z, off_dh[31:0]);
      h = camera(row_h, x, y, z, off_dh[63:32]);
      v = camera(row_v, x, y, z, off_vn[31:0]);
      nr = longint'($signed(off_vn[63:32]));
      r.flags = '0;
      if (clip) begin
        ah = h < 0 ? -h : h;
        av = v < 0 ? -v : v;
        if (d < nr) r.flags[vtcp_pkg::OC_NEAR] = 1'b1;
        if (av > d) begin
          if (v > d) r.flags[vtcp_pkg::OC_BOTTOM] = 1'b1;
          else r.flags[vtcp_pkg::OC_TOP] = 1'b1;
        end
        if (ah > d) begin
          if (h > d) r.flags[vtcp_pkg::OC_RIGHT] = 1'b1;
          else r.flags[vtcp_pkg::OC_LEFT] = 1'b1;
        end
      end
      r.px = 32'(pixel(h, d, map_x));
      r.py = 32'(pixel(v, d, map_y));
      r.dep = 32'(d);
      r.hz = 32'(h);
      r.vt = 32'(v);
      r.zero = (d == 0);
      r.last = last;
      pending.push_back(r);
    endfunction

    function void check_result(vtx_result_t got);
      vtx_result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, nothing pending");
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp px=%h py=%h d=%h h=%h v=%h fl=%b z=%b l=%b",
                   exp_r.px, exp_r.py, exp_r.dep, exp_r.hz, exp_r.vt, exp_r.flags,
                   exp_r.zero, exp_r.last);
          $display("          got px=%h py=%h d=%h h=%h v=%h fl=%b z=%b l=%b",
                   got.px, got.py, got.dep, got.hz, got.vt, got.flags,
                   got.zero, got.last);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] vertex_x_i = '0, vertex_y_i = '0, vertex_z_i = '0;
  logic clip_enable_i = 1'b0, last_in_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [vtcp_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [vtcp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [31:0] pixel_x_o, pixel_y_o, depth_o, cam_horiz_o, cam_vert_o;
  logic [4:0] clip_flags_o;
  logic zero_depth_o, last_out_o;

  proj_scoreboard sb = new();
  longint unsigned cycle_cnt = 0;
  int idle_pct = 27;

  always #5 clk_i = ~clk_i;

  vertex_transform_clip_project_core DUT (.*);

  // Monitor: input transfers and result strobes
  always @(posedge clk_i) begin
    vtx_result_t got;
    if (rst_ni && start && !busy)
      sb.note_input(vertex_x_i, vertex_y_i, vertex_z_i, clip_enable_i, last_in_i);
    if (rst_ni && done_o) begin
      got.px = pixel_x_o;
      got.py = pixel_y_o;
      got.dep = depth_o;
      got.hz = cam_horiz_o;
      got.vt = cam_vert_o;
      got.flags = clip_flags_o;
      got.zero = zero_depth_o;
      got.last = last_out_o;
      sb.check_result(got);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Leaves cfg_valid_i high; cfg_close lowers it after a batch of writes
  task automatic cfg_write(logic [vtcp_pkg::CFG_IDX_W-1:0] idx,
                           logic [vtcp_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  task automatic cfg_close();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic clip, logic last);
    int gap;
    gap = 0;
    // Each cycle idles with probability idle_pct percent
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    vertex_z_i <= z;
    clip_enable_i <= clip;
    last_in_i <= last;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 10;
      default: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
    endcase
  endfunction

  // Coefficient row: small tidy values mostly, sometimes raw bits
  function automatic logic [vtcp_pkg::CFG_DATA_W-1:0] rand_row(bit extreme);
    logic [vtcp_pkg::CFG_DATA_W-1:0] r;
    r = {$urandom(), $urandom()};
    if (extreme) return $urandom_range(0, 1) ? {4'hF, 60'hFFFF_FFFF_FFFF_FFF}
                                            : {4'h0, 20'h7FFFF, 20'h80000, 20'h7FFFF};
    if ($urandom_range(0, 3) != 0)
      for (int j = 0; j < 3; j++)
        r[20*j +: 20] = 20'($signed($urandom_range(0, 64)) - 32) <<< 11;
    return r;
  endfunction

  function automatic logic [vtcp_pkg::CFG_DATA_W-1:0] rand_pair(int kind);
    logic [31:0] lo, hi;
    lo = $urandom();
    hi = $urandom();
    if (kind == 1) begin
      lo = 32'($signed($urandom_range(0, 64)) - 32) <<< 14;
      hi = 32'($signed($urandom_range(0, 64)) - 32) <<< 14;
    end else if (kind == 2) begin
      lo = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      hi = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    return {hi, lo};
  endfunction

  task automatic program_phase(int phase);
    bit ext;
    int kind;
    ext = (phase == 1);
    kind = (phase == 1) ? 2 : (phase % 3 == 0 ? 0 : 1);
    cfg_write(vtcp_pkg::REG_ROT_DEPTH, rand_row(ext));
    cfg_write(vtcp_pkg::REG_ROT_HORIZ, rand_row(ext));
    cfg_write(vtcp_pkg::REG_ROT_VERT, rand_row(ext));
    cfg_write(vtcp_pkg::REG_OFF_DH, rand_pair(kind));
    cfg_write(vtcp_pkg::REG_OFF_VN, rand_pair(kind));
    cfg_write(vtcp_pkg::REG_PIX_X, rand_pair(kind));
    cfg_write(vtcp_pkg::REG_PIX_Y, rand_pair(kind));
    cfg_write(REG_NONE, {$urandom(), $urandom()});
    cfg_close();
  endtask

  initial begin
    int n_phase;
    int mode;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed vertices against the reset matrix: depth=x, horiz=y, vert=z
    send_vertex(32'sh0002_0000, 32'sh0003_0000, 32'sh0, 1'b1, 1'b0);   // right
    send_vertex(32'sh0002_0000, -32'sh0003_0000, 32'sh0, 1'b1, 1'b0);  // left
    send_vertex(32'sh0002_0000, 32'sh0, 32'sh0003_0000, 1'b1, 1'b0);   // bottom
    send_vertex(32'sh0002_0000, 32'sh0, -32'sh0003_0000, 1'b1, 1'b1);  // top
    send_vertex(32'sh0000_8000, 32'sh0, 32'sh0, 1'b1, 1'b0);           // near
    send_vertex(32'sh0, 32'sh0001_0000, -32'sh0001_0000, 1'b1, 1'b0);  // zero depth
    send_vertex(32'sh0, -32'sh0001_0000, 32'sh0, 1'b0, 1'b1);          // zero depth, no clip
    send_vertex(32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0);
    send_vertex(-32'sh0004_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1, 1'b0);
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 1'b1);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b0);
    send_vertex(32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0);
    send_vertex(32'sh0000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_vertex(32'shFFFF_FFFF, 32'sh0001_0000, 32'sh0001_0000, 1'b1, 1'b1);
    send_vertex(32'sh0010_0000, 32'sh0008_0000, -32'sh0008_0000, 1'b0, 1'b0);
    drain();

    // Extreme registers, then four more directed vertices
    program_phase(1);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0);
    send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b1);
    send_vertex(32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0);
    send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000, 1'b0, 1'b1);
    drain();

    // Random phases; every phase after the first programs its own register setting
    n_phase = 7;
    for (int p = 0; p < n_phase; p++) begin
      if (p > 0) program_phase(p + 1);
      for (int i = 0; i < N_RANDOM / n_phase; i++) begin
        idle_pct = (p == 2) ? 0 : 27;
        if (p == 3 && i == 100) drain();
        mode = $urandom_range(0, 9);
        mode = (mode < 2) ? 0 : (mode < 3) ? 1 : (mode < 6) ? 2 : 3;
        send_vertex(rand_coord(mode),
                    rand_coord($urandom_range(0, 3)),
                    ($urandom_range(0, 15) == 0) ? 32'sh0 : rand_coord($urandom_range(0, 3)),
                    ($urandom_range(0, 3) != 0), ($urandom_range(0, 7) == 0));
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/vtcp_pkg.sv
design/vtcp_div.sv
design/vertex_transform_clip_project_core.sv
design/vtcp_checker.sv
verif/vertex_transform_clip_project_core_tb.sv
